// ===== hw/rtl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and field widths for the byte ring FIFO with commit pointer.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int ALIGN_W = 11;
  localparam int REQ_W   = 7;
  localparam int LEN_W   = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT_REFUSE    = 3'd0,
    KIND_PUT_OVERWRITE = 3'd1,
    KIND_COMMIT        = 3'd2,
    KIND_COMMIT_ALIGN  = 3'd3,
    KIND_READ          = 3'd4,
    KIND_PEEK          = 3'd5,
    KIND_FLUSH         = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STREAM,
    ST_DIVIDE
  } state_t;

endpackage

// ===== hw/rtl/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram
// Ring byte store: one write port, one read port, registered read data that
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module brf_ram
  import brf_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/brf_rem.sv =====
// ----------------------------------------------------------------------------
// brf_rem
// Restoring remainder unit: dividend mod divisor, one dividend bit a cycle.
// ----------------------------------------------------------------------------
module brf_rem
  import brf_pkg::*;
#(
  parameter int DW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [ALIGN_W-1:0] divisor,
  output logic               busy,
  output logic [ALIGN_W-1:0] rem
);

  localparam int CTW = $clog2(DW + 1);

  logic               busy_r;
  logic [CTW-1:0]     cnt_r;
  logic [DW-1:0]      dvd_r;
  logic [ALIGN_W-1:0] div_r;
  logic [ALIGN_W-1:0] rem_r;
  logic [ALIGN_W:0]   trial;
  logic [ALIGN_W:0]   diff;
  logic               ge;

  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    ge    = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CTW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CTW'(1);
      if (cnt_r == CTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? diff[ALIGN_W-1:0] : trial[ALIGN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/byte_ring_fifo_with_commit.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_commit
// Put, commit, flush and empty requests: status beat registered on the next
//   edge; one such item per cycle while the output is not stalled.
// Aligned commit: bit-serial remainder unless align is 0 or above stored length.
// Read/peek of n bytes: one byte beat per cycle from the ring store read port
//   while the output is not stalled.
// Synchronous reset clears pointers and full flag; ring contents are kept.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_commit
  import brf_pkg::*;
#(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic [ALIGN_W-1:0] in_align,
  input  logic [REQ_W-1:0]   in_request_len,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last,
  output logic [REQ_W-1:0]   out_read_count,
  output logic               out_accepted,
  output logic [LEN_W-1:0]   out_stored_len,
  output logic [LEN_W-1:0]   out_committed_len,
  output logic               out_full_res
);

  localparam int PW = $clog2(DEPTH);
  localparam int SW = PW + 1;
  localparam int CW = 17;

  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] x);
    return (x >= SW'(DEPTH)) ? PW'(x - SW'(DEPTH)) : PW'(x);
  endfunction

  function automatic logic [SW-1:0] ring_span(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a >= b) ? (SW'(a) - SW'(b)) : (SW'(DEPTH) - SW'(b) + SW'(a));
  endfunction

  function automatic logic [SW-1:0] comm(input logic [PW-1:0] c, input logic [PW-1:0] r,
                                         input logic f);
    return (f && (c == r)) ? SW'(DEPTH) : ring_span(c, r);
  endfunction

  state_t st_r, st_nxt;
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [PW-1:0]    cp_r, cp_nxt;
  logic             full_r, full_nxt;
  logic [PW-1:0]    addr_r, addr_nxt;
  logic [REQ_W-1:0] remain_r, remain_nxt;
  logic [REQ_W-1:0] cnt_r, cnt_nxt;

  logic               out_valid_r;
  logic               data_r;
  logic               last_r;
  logic [REQ_W-1:0]   rc_r;
  logic               acc_r;
  logic [LEN_W-1:0]   sl_r;
  logic [LEN_W-1:0]   cl_r;
  logic               fr_r;

  logic               in_accept;
  logic               out_load;
  logic               emit;
  logic               e_data;
  logic               e_last;
  logic [REQ_W-1:0]   e_cnt;
  logic               e_acc;
  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_q;
  logic               div_start;
  logic               div_busy;
  logic [ALIGN_W-1:0] div_rem;

  logic [SW-1:0]    stored_cur;
  logic [SW-1:0]    avail_cur;
  logic [REQ_W-1:0] req_sat;
  logic [REQ_W-1:0] n_rd;
  logic [PW-1:0]    wp_inc;
  logic [PW-1:0]    rp_adv;
  logic [PW-1:0]    cp_quick;
  logic [PW-1:0]    cp_div;
  logic [PW-1:0]    addr_inc;

  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = (st_r != ST_IDLE) || !out_load;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    stored_cur = ring_span(wp_r, rp_r);
    avail_cur  = comm(cp_r, rp_r, full_r);
    req_sat    = (in_request_len > REQ_W'(MAX_READ)) ? REQ_W'(MAX_READ) : in_request_len;
    n_rd       = (CW'(avail_cur) < CW'(req_sat)) ? REQ_W'(avail_cur) : req_sat;
    wp_inc     = wrap(SW'(wp_r) + SW'(1));
    rp_adv     = wrap(SW'(rp_r) + SW'(n_rd));
    cp_quick   = wrap(SW'(cp_r) + stored_cur);
    cp_div     = wrap(SW'(cp_r) + stored_cur - SW'(div_rem));
    addr_inc   = wrap(SW'(addr_r) + SW'(1));
  end

  always_comb begin
    st_nxt     = st_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    cp_nxt     = cp_r;
    full_nxt   = full_r;
    addr_nxt   = addr_r;
    remain_nxt = remain_r;
    cnt_nxt    = cnt_r;
    emit       = 1'b0;
    e_data     = 1'b0;
    e_last     = 1'b1;
    e_cnt      = '0;
    e_acc      = 1'b1;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_accept) begin
          emit = 1'b1;
          case (kind_t'(in_kind))
            KIND_PUT_REFUSE, KIND_PUT_OVERWRITE: begin
              if (full_r && (kind_t'(in_kind) == KIND_PUT_REFUSE)) begin
                e_acc = 1'b0;
              end else begin
                ram_we = 1'b1;
                wp_nxt = wp_inc;
                if (wp_inc == rp_r) begin
                  full_nxt = 1'b1;
                end
              end
            end
            KIND_COMMIT: begin
              cp_nxt = wp_r;
            end
            KIND_COMMIT_ALIGN: begin
              if ((in_align == '0) || (CW'(stored_cur) < CW'(in_align))) begin
                cp_nxt = cp_quick;
              end else begin
                emit      = 1'b0;
                div_start = 1'b1;
                st_nxt    = ST_DIVIDE;
              end
            end
            KIND_READ, KIND_PEEK: begin
              if (in_request_len != '0) begin
                full_nxt = 1'b0;
                if (n_rd != '0) begin
                  emit       = 1'b0;
                  st_nxt     = ST_STREAM;
                  addr_nxt   = rp_r;
                  remain_nxt = n_rd;
                  cnt_nxt    = n_rd;
                  if (kind_t'(in_kind) == KIND_READ) begin
                    rp_nxt = rp_adv;
                  end
                end
              end
            end
            KIND_FLUSH: begin
              wp_nxt   = '0;
              rp_nxt   = '0;
              cp_nxt   = '0;
              full_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_STREAM: begin
        if (out_load) begin
          emit       = 1'b1;
          e_data     = 1'b1;
          e_last     = (remain_r == REQ_W'(1));
          e_cnt      = cnt_r;
          ram_re     = 1'b1;
          addr_nxt   = addr_inc;
          remain_nxt = remain_r - REQ_W'(1);
          if (remain_r == REQ_W'(1)) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_DIVIDE: begin
        if (!div_busy && out_load) begin
          emit   = 1'b1;
          cp_nxt = cp_div;
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      cp_r        <= '0;
      full_r      <= 1'b0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      cp_r        <= cp_nxt;
      full_r      <= full_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= emit || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
    if (emit) begin
      data_r <= e_data;
      last_r <= e_last;
      rc_r   <= e_cnt;
      acc_r  <= e_acc;
      sl_r   <= LEN_W'(ring_span(wp_nxt, rp_nxt));
      cl_r   <= LEN_W'(comm(cp_nxt, rp_nxt, full_nxt));
      fr_r   <= full_nxt;
    end
  end

  brf_ram #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_byte),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_q)
  );

  brf_rem #(
    .DW (PW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (stored_cur[PW-1:0]),
    .divisor  (in_align),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  assign out_valid         = out_valid_r;
  assign out_byte          = data_r ? ram_q : '0;
  assign out_last          = last_r;
  assign out_read_count    = rc_r;
  assign out_accepted      = acc_r;
  assign out_stored_len    = sl_r;
  assign out_committed_len = cl_r;
  assign out_full_res      = fr_r;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(wp_r) < SW'(DEPTH)) && (SW'(rp_r) < SW'(DEPTH)) && (SW'(cp_r) < SW'(DEPTH)))
    else $error("ring pointer out of range");

  a_stream_remain: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_STREAM) |-> (remain_r != '0))
    else $error("byte stream with nothing left to send");

  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_STREAM && out_load && remain_r == REQ_W'(1)) |=>
      (st_r == ST_IDLE && out_valid && out_last))
    else $error("last byte beat not marked or sequencer not back in idle");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !div_busy)
    else $error("remainder unit busy while sequencer idle");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte ring FIFO with commit pointer. Put,
// commit, aligned commit, read, peek and flush requests are driven in bursts
// against a stalling receiver; every result beat is checked against a
// bit-accurate model of the ring, its three pointers and the full flag.
// ----------------------------------------------------------------------------
import brf_pkg::*;

localparam int RING_DEPTH = 1024;
localparam int READ_MAX   = 64;
localparam int PTR_W      = $clog2(RING_DEPTH);
localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd7;

typedef struct packed {
  logic [BYTE_W-1:0] data;
  logic              last;
  logic [REQ_W-1:0]  count;
  logic              accepted;
  logic [LEN_W-1:0]  stored;
  logic [LEN_W-1:0]  committed;
  logic              full;
} ring_beat_t;

class ring_tracker;
  ring_beat_t        pending_beats[$];
  logic [BYTE_W-1:0] ring_bytes[RING_DEPTH];
  bit                ring_written[RING_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  cm_ptr;
  bit                full;
  int                errors;

  function new();
    wr_ptr = '0;
    rd_ptr = '0;
    cm_ptr = '0;
    full   = 1'b0;
    errors = 0;
    foreach (ring_written[i]) ring_written[i] = 1'b0;
  endfunction

  function logic [LEN_W-1:0] stored_count();
    logic [PTR_W-1:0] delta;
    delta = wr_ptr - rd_ptr;
    stored_count = LEN_W'(delta);
  endfunction

  function logic [LEN_W-1:0] committed_count();
    logic [PTR_W-1:0] delta;
    delta = cm_ptr - rd_ptr;
    if (full && rd_ptr == cm_ptr) committed_count = LEN_W'(RING_DEPTH);
    else committed_count = LEN_W'(delta);
  endfunction

  // Shortens a read so that it never touches a ring entry not yet written.
  function logic [REQ_W-1:0] clamp_request(logic [REQ_W-1:0] req);
    int want;
    int n;
    int run;
    want = (req > READ_MAX) ? READ_MAX : req;
    n    = (want < committed_count()) ? want : committed_count();
    run  = 0;
    while (run < n && ring_written[(rd_ptr + run) % RING_DEPTH]) run++;
    if (run < n) return REQ_W'(run);
    return req;
  endfunction

  function void push_beat(logic [BYTE_W-1:0] data, bit last, int n, bit ok);
    ring_beat_t beat;
    beat.data      = data;
    beat.last      = last;
    beat.count     = REQ_W'(n);
    beat.accepted  = ok;
    beat.stored    = stored_count();
    beat.committed = committed_count();
    beat.full      = full;
    pending_beats.push_back(beat);
  endfunction

  function void store_byte(logic [BYTE_W-1:0] value);
    if (wr_ptr + 10'd1 == rd_ptr) full = 1'b1;
    ring_bytes[wr_ptr]   = value;
    ring_written[wr_ptr] = 1'b1;
    wr_ptr               = wr_ptr + 10'd1;
  endfunction

  function void accept_request(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] value,
                               logic [ALIGN_W-1:0] align, logic [REQ_W-1:0] req);
    int               len;
    int               want;
    int               avail;
    int               n;
    logic [PTR_W-1:0] start;
    bit               ok;
    ok = 1'b1;
    case (kind)
      KIND_PUT_REFUSE: begin
        if (full) ok = 1'b0;
        else store_byte(value);
      end
      KIND_PUT_OVERWRITE: store_byte(value);
      KIND_COMMIT: cm_ptr = wr_ptr;
      KIND_COMMIT_ALIGN: begin
        len = stored_count();
        if (align != 0 && len >= align) len = len - (len % align);
        cm_ptr = cm_ptr + len[PTR_W-1:0];
      end
      KIND_READ, KIND_PEEK: begin
        if (req != 0) begin
          avail = committed_count();
          full  = 1'b0;
          want  = (req > READ_MAX) ? READ_MAX : req;
          n     = (want < avail) ? want : avail;
          if (n > 0) begin
            start = rd_ptr;
            if (kind == KIND_READ) rd_ptr = rd_ptr + n[PTR_W-1:0];
            for (int i = 0; i < n; i++)
              push_beat(ring_bytes[(start + i) % RING_DEPTH], i == n - 1, n, 1'b1);
            return;
          end
        end
      end
      KIND_FLUSH: begin
        wr_ptr = '0;
        rd_ptr = '0;
        cm_ptr = '0;
        full   = 1'b0;
      end
      default: ;
    endcase
    push_beat('0, 1'b1, 0, ok);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_beat(ring_beat_t got);
    ring_beat_t want;
    if (pending_beats.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual byte %0d", $time, got.data);
      errors++;
      return;
    end
    want = pending_beats.pop_front();
    compare_field("out_byte", want.data, got.data);
    compare_field("out_last", want.last, got.last);
    compare_field("out_read_count", want.count, got.count);
    compare_field("out_accepted", want.accepted, got.accepted);
    compare_field("out_stored_len", want.stored, got.stored);
    compare_field("out_committed_len", want.committed, got.committed);
    compare_field("out_full_res", want.full, got.full);
  endfunction
endclass

module tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [KIND_W-1:0]  in_kind = '0;
  logic [BYTE_W-1:0]  in_byte = '0;
  logic [ALIGN_W-1:0] in_align = '0;
  logic [REQ_W-1:0]   in_request_len = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;
  logic [REQ_W-1:0]   out_read_count;
  logic               out_accepted;
  logic [LEN_W-1:0]   out_stored_len;
  logic [LEN_W-1:0]   out_committed_len;
  logic               out_full_res;

  ring_tracker tracker = new();
  int          sent_items = 0;
  int          burst_left = 0;
  int          gap_cycles = 0;
  bit          primed = 1'b0;

  byte_ring_fifo_with_commit #(
    .DEPTH    (RING_DEPTH),
    .MAX_READ (READ_MAX)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_byte           (in_byte),
    .in_align          (in_align),
    .in_request_len    (in_request_len),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .out_read_count    (out_read_count),
    .out_accepted      (out_accepted),
    .out_stored_len    (out_stored_len),
    .out_committed_len (out_committed_len),
    .out_full_res      (out_full_res)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_beat({out_byte, out_last, out_read_count, out_accepted,
                          out_stored_len, out_committed_len, out_full_res});
  end

  // receiver: stretches of free flow, coin-toss stalls, a repeating
  // 8-bit pattern, or heavy back-pressure
  initial begin
    int          mode;
    int          span;
    logic [7:0]  pattern;
    @(posedge rst_n);
    forever begin
      mode    = $urandom_range(0, 3);
      span    = $urandom_range(16, 160);
      pattern = $urandom_range(0, 255);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = $urandom_range(0, 1);
          2: out_stall = pattern[i % 8];
          default: out_stall = ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  function automatic logic [ALIGN_W-1:0] pick_align();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(1024, 2047);
      2: return $urandom_range(1, 1023);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_request();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(65, 127);
      2: return READ_MAX;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] value,
                              input logic [ALIGN_W-1:0] align, input logic [REQ_W-1:0] req);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_cycles > 0) begin
        in_valid = 1'b0;
        repeat (gap_cycles) @(negedge clk);
      end
    end
    burst_left--;
    if (kind == KIND_READ || kind == KIND_PEEK) req = tracker.clamp_request(req);
    in_valid       = 1'b1;
    in_kind        = kind;
    in_byte        = value;
    in_align       = align;
    in_request_len = req;
    do @(posedge clk); while (in_stall);
    tracker.accept_request(kind, value, align, req);
    if (kind != KIND_RESERVED) sent_items++;
  endtask

  task automatic put_random();
    send_request($urandom_range(0, 1) ? KIND_PUT_REFUSE : KIND_PUT_OVERWRITE,
                 $urandom_range(0, 255), pick_align(), pick_request());
  endtask

  task automatic take_random();
    send_request($urandom_range(0, 2) ? KIND_READ : KIND_PEEK,
                 $urandom_range(0, 255), pick_align(), pick_request());
  endtask

  task automatic run_produce();
    repeat ($urandom_range(1, 12)) put_random();
    if ($urandom_range(0, 1)) send_request(KIND_COMMIT, $urandom_range(0, 255), pick_align(), 0);
    else send_request(KIND_COMMIT_ALIGN, $urandom_range(0, 255), pick_align(), 0);
    repeat ($urandom_range(1, 3)) take_random();
  endtask

  // commit past the write pointer and read beyond it, then put until the
  // write pointer catches the read pointer and the ring reports full, at most 40 puts
  task automatic run_fill();
    int               guard;
    logic [ALIGN_W-1:0] align;
    send_request(KIND_FLUSH, $urandom_range(0, 255), pick_align(), pick_request());
    if (!primed) begin
      repeat ($urandom_range(100, 120)) put_random();
      send_request(KIND_FLUSH, 0, 0, 0);
      primed = 1'b1;
    end
    repeat ($urandom_range(2, 8)) put_random();
    repeat ($urandom_range(2, 4)) begin
      case ($urandom_range(0, 2))
        0: align = '0;
        1: align = 11'd1;
        default: align = 11'h7FF;
      endcase
      send_request(KIND_COMMIT_ALIGN, $urandom_range(0, 255), align, 0);
    end
    send_request(KIND_READ, $urandom_range(0, 255), 0, REQ_W'(tracker.committed_count()));
    guard = 0;
    while (!tracker.full && guard < 40) begin
      put_random();
      guard++;
    end
    send_request(KIND_PUT_REFUSE, $urandom_range(0, 255), 0, 0);
    if ($urandom_range(0, 1))
      send_request(KIND_PUT_OVERWRITE, $urandom_range(0, 255), 0, 0);
    send_request(KIND_COMMIT, 0, 0, 0);
    send_request($urandom_range(0, 1) ? KIND_READ : KIND_PEEK, 0, 0, $urandom_range(40, 127));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 4))
      send_request($urandom_range(0, 7), $urandom_range(0, 255),
                   $urandom_range(0, 2047), $urandom_range(0, 127));
  endtask

  initial begin
    int sel;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(KIND_READ, 0, 0, 5);
    send_request(KIND_PEEK, 0, 0, 0);
    send_request(KIND_RESERVED, 8'hFF, 11'h7FF, 7'h7F);
    send_request(KIND_PUT_REFUSE, 8'h00, 0, 0);
    send_request(KIND_PUT_OVERWRITE, 8'hFF, 0, 0);
    send_request(KIND_PUT_REFUSE, 8'hA5, 0, 0);
    send_request(KIND_PUT_OVERWRITE, 8'h5A, 0, 0);
    send_request(KIND_COMMIT_ALIGN, 0, 0, 0);
    send_request(KIND_PUT_REFUSE, 8'h01, 0, 0);
    send_request(KIND_PUT_OVERWRITE, 8'h80, 0, 0);
    send_request(KIND_COMMIT_ALIGN, 0, 11'd4, 0);
    send_request(KIND_COMMIT_ALIGN, 0, 11'h7FF, 0);
    send_request(KIND_COMMIT, 0, 0, 0);
    send_request(KIND_PEEK, 0, 0, 7'h7F);
    send_request(KIND_READ, 0, 0, 2);
    send_request(KIND_PEEK, 0, 0, 0);
    send_request(KIND_READ, 0, 0, READ_MAX);
    send_request(KIND_READ, 0, 0, 3);
    send_request(KIND_FLUSH, 0, 0, 0);
    send_request(KIND_PEEK, 0, 0, 1);
    send_request(KIND_PUT_OVERWRITE, 8'h3C, 0, 0);
    send_request(KIND_COMMIT, 0, 0, 0);
    send_request(KIND_READ, 0, 0, 1);

    run_fill();
    while (sent_items < 410) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) run_produce();
      else if (sel < 68) take_random();
      else if (sel < 76) run_fill();
      else if (sel < 84)
        send_request(KIND_FLUSH, $urandom_range(0, 255), pick_align(), pick_request());
      else run_noise();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/brf_pkg.sv
hw/rtl/brf_ram.sv
hw/rtl/brf_rem.sv
hw/rtl/byte_ring_fifo_with_commit.sv
sim/tb.sv
